### rtl/frga_pkg.sv
// Shared constants, font tables and controller/datapath link types.
package frga_pkg;

  localparam int unsigned FontCount  = 18;
  localparam int unsigned SelW       = 5;
  localparam int unsigned RowW       = 7;
  localparam int unsigned ColW       = 7;
  localparam int unsigned IdxW       = 13;
  localparam int unsigned ProdW      = 21;
  localparam int unsigned AddrW      = 24;

  localparam logic [SelW-1:0] FirstAsciiSel = 5'd4;
  localparam logic [SelW-1:0] ReservedSel   = 5'd18;

  localparam logic [7:0] GbRow1Lo   = 8'hA1;
  localparam logic [7:0] GbRow1Hi   = 8'hA9;
  localparam logic [7:0] GbRow2Lo   = 8'hB0;
  localparam logic [7:0] GbRow2Hi   = 8'hF7;
  localparam logic [7:0] GbTrailLo  = 8'hA1;
  localparam logic [7:0] GbRow2Skip = 8'd9;   // 846 = 9 rows of 94
  localparam logic [7:0] AsciiLo    = 8'h20;
  localparam logic [7:0] AsciiHi    = 8'h7E;
  localparam logic [IdxW-1:0] GbRowLen = 13'd94;

  typedef struct packed {
    logic accept;
    logic step_row;
    logic step_scale;
    logic load;
  } frga_cmd_t;

  typedef struct packed {
    logic emits;
    logic out_free;
  } frga_sts_t;

  function automatic logic [AddrW-1:0] font_base(input logic [SelW-1:0] sel);
    logic [AddrW-1:0] b;
    case (sel)
      5'd0:    b = 24'h000000;
      5'd1:    b = 24'h02C9D0;
      5'd2:    b = 24'h068190;
      5'd3:    b = 24'h0EDF00;
      5'd4:    b = 24'h1DDF80;
      5'd5:    b = 24'h1DE280;
      5'd6:    b = 24'h1DBE00;
      5'd7:    b = 24'h1DD780;
      5'd8:    b = 24'h1DFF00;
      5'd9:    b = 24'h1E5A50;
      5'd10:   b = 24'h1DC400;
      5'd11:   b = 24'h1DE580;
      5'd12:   b = 24'h1E22D0;
      5'd13:   b = 24'h1E99D0;
      5'd14:   b = 24'h1DCDC0;
      5'd15:   b = 24'h1DF240;
      5'd16:   b = 24'h1E3E90;
      5'd17:   b = 24'h1ECA90;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] font_bytes(input logic [SelW-1:0] sel);
    logic [7:0] n;
    case (sel)
      5'd0:    n = 8'd24;
      5'd1:    n = 8'd32;
      5'd2:    n = 8'd72;
      5'd3:    n = 8'd128;
      5'd4:    n = 8'd8;
      5'd5:    n = 8'd8;
      5'd6:    n = 8'd12;
      5'd7:    n = 8'd16;
      5'd8:    n = 8'd48;
      5'd9:    n = 8'd64;
      5'd10:   n = 8'd26;
      5'd11:   n = 8'd34;
      5'd12:   n = 8'd74;
      5'd13:   n = 8'd130;
      5'd14:   n = 8'd26;
      5'd15:   n = 8'd34;
      5'd16:   n = 8'd74;
      5'd17:   n = 8'd130;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] font_adv(input logic [SelW-1:0] sel);
    logic [7:0] a;
    case (sel)
      5'd0:    a = 8'd12;
      5'd1:    a = 8'd16;
      5'd2:    a = 8'd24;
      5'd3:    a = 8'd32;
      5'd4:    a = 8'd6;
      5'd5:    a = 8'd7;
      5'd6:    a = 8'd6;
      5'd7:    a = 8'd8;
      5'd8:    a = 8'd12;
      5'd9:    a = 8'd16;
      5'd10:   a = 8'd10;
      5'd11:   a = 8'd12;
      5'd12:   a = 8'd20;
      5'd13:   a = 8'd25;
      5'd14:   a = 8'd10;
      5'd15:   a = 8'd12;
      5'd16:   a = 8'd20;
      5'd17:   a = 8'd25;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/frga_in_if.sv
// Text byte channel: valid/ready handshake with the input item fields.
interface frga_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        start_of_text;
  logic [15:0] origin_x;
  logic [15:0] origin_y;

  modport source (output valid, text_byte, start_of_text, origin_x, origin_y, input ready);
  modport sink   (input valid, text_byte, start_of_text, origin_x, origin_y, output ready);
endinterface

### rtl/frga_out_if.sv
// Glyph cell channel: valid/ready handshake with the result item fields.
interface frga_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rom_address;
  logic [7:0]  glyph_bytes;
  logic [15:0] cell_x;
  logic [15:0] cell_y;
  logic        glyph_valid;

  modport source (output valid, rom_address, glyph_bytes, cell_x, cell_y, glyph_valid,
                  input ready);
  modport sink   (input valid, rom_address, glyph_bytes, cell_x, cell_y, glyph_valid,
                  output ready);
endinterface

### rtl/frga_ctrl.sv
// Sequencer: accepts a byte, steps the address datapath, loads the output register.
module frga_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frga_pkg::frga_sts_t sts,
  output frga_pkg::frga_cmd_t cmd
);
  import frga_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_SCALE,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.emits) begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.step_row = 1'b1;
        state_nxt    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.step_scale = 1'b1;
        state_nxt      = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_row_then_scale: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROW |=> state_r == ST_SCALE)
    else $error("row step not followed by scale step");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("output register overwritten while occupied");

  a_silent_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !sts.emits) |=> state_r == ST_IDLE)
    else $error("byte without result left idle");

endmodule

### rtl/frga_dp.sv
// Datapath: cursor and lead-byte state, glyph index, address arithmetic, output register.
module frga_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic [7:0]          text_byte,
  input  logic                start_of_text,
  input  logic [15:0]         origin_x,
  input  logic [15:0]         origin_y,
  input  frga_pkg::frga_cmd_t cmd,
  output frga_pkg::frga_sts_t sts,
  frga_out_if.source          out_ch
);
  import frga_pkg::*;

  logic [SelW-1:0]  font_select_r;
  logic [15:0]      cursor_x_r, line_y_r;
  logic [7:0]       lead_byte_r;
  logic             lead_pending_r;

  logic             ok_r;
  logic [RowW-1:0]  row_r;
  logic [ColW-1:0]  col_r;
  logic [15:0]      cell_x_r, cell_y_r;
  logic [IdxW-1:0]  idx_r;
  logic [ProdW-1:0] prod_r;

  logic             out_valid_r, out_gv_r;
  logic [AddrW-1:0] out_addr_r;
  logic [7:0]       out_bytes_r;
  logic [15:0]      out_x_r, out_y_r;

  logic [15:0]      cur_x, cur_y;
  logic             pend, is_zero, reserved, gb_mode;
  logic             lead_in_r1, lead_in_r2, trail_ok, ascii_ok, ok;
  logic [7:0]       lead_off, lead_off2, col_off, asc_off;
  logic [RowW-1:0]  row;
  logic [ColW-1:0]  col;
  logic [AddrW-1:0] addr;

  always_comb begin
    cur_x    = start_of_text ? origin_x : cursor_x_r;
    cur_y    = start_of_text ? origin_y : line_y_r;
    pend     = start_of_text ? 1'b0 : lead_pending_r;
    is_zero  = (text_byte == 8'd0);
    reserved = (font_select_r >= ReservedSel);
    gb_mode  = (font_select_r < FirstAsciiSel);

    lead_in_r1 = (lead_byte_r >= GbRow1Lo) && (lead_byte_r <= GbRow1Hi);
    lead_in_r2 = (lead_byte_r >= GbRow2Lo) && (lead_byte_r <= GbRow2Hi);
    trail_ok   = (text_byte >= GbTrailLo);
    ascii_ok   = (text_byte >= AsciiLo) && (text_byte <= AsciiHi);

    lead_off  = lead_byte_r - GbRow1Lo;
    lead_off2 = lead_byte_r - GbRow2Lo + GbRow2Skip;
    col_off   = text_byte - GbTrailLo;
    asc_off   = text_byte - AsciiLo;

    if (gb_mode) begin
      ok  = trail_ok && (lead_in_r1 || lead_in_r2);
      row = lead_in_r1 ? lead_off[RowW-1:0] : lead_off2[RowW-1:0];
      col = col_off[ColW-1:0];
    end else begin
      ok  = ascii_ok && !reserved;
      row = '0;
      col = asc_off[ColW-1:0];
    end

    // a lead byte in GB2312 mode and a terminator give no cell
    sts.emits    = !is_zero && (reserved || !gb_mode || pend);
    sts.out_free = !out_valid_r || out_ch.ready;

    addr = {{(AddrW-ProdW){1'b0}}, prod_r} + font_base(font_select_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_select_r  <= '0;
      cursor_x_r     <= '0;
      line_y_r       <= '0;
      lead_byte_r    <= '0;
      lead_pending_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        font_select_r <= cfg_wr_data;
      end
      if (cmd.accept) begin
        line_y_r   <= cur_y;
        cursor_x_r <= sts.emits ? cur_x + {8'd0, font_adv(font_select_r)} : cur_x;
        if (!is_zero && gb_mode && !reserved && !pend) begin
          lead_byte_r    <= text_byte;
          lead_pending_r <= 1'b1;
        end else begin
          lead_pending_r <= 1'b0;
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ok_r     <= ok;
      row_r    <= row;
      col_r    <= col;
      cell_x_r <= cur_x;
      cell_y_r <= cur_y;
    end
    if (cmd.step_row) begin
      idx_r <= {{(IdxW-RowW){1'b0}}, row_r} * GbRowLen + {{(IdxW-ColW){1'b0}}, col_r};
    end
    if (cmd.step_scale) begin
      prod_r <= {{(ProdW-IdxW){1'b0}}, idx_r} * {{(ProdW-8){1'b0}}, font_bytes(font_select_r)};
    end
    if (cmd.load) begin
      out_gv_r    <= ok_r;
      out_addr_r  <= ok_r ? addr : '0;
      out_bytes_r <= ok_r ? font_bytes(font_select_r) : '0;
      out_x_r     <= cell_x_r;
      out_y_r     <= cell_y_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.rom_address = out_addr_r;
  assign out_ch.glyph_bytes = out_bytes_r;
  assign out_ch.cell_x      = out_x_r;
  assign out_ch.cell_y      = out_y_r;
  assign out_ch.glyph_valid = out_gv_r;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_skip_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_gv_r) |-> (out_addr_r == '0 && out_bytes_r == '0))
    else $error("skipped cell carries address or size");

  a_no_lead_outside_gb: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !is_zero && !gb_mode) |=> !lead_pending_r)
    else $error("lead byte kept outside GB2312 mode");

endmodule

### rtl/font_rom_glyph_address_generator.sv
// Top level: font ROM glyph address generator, sequencer plus address datapath.
// A result-giving transaction steps through acceptance, row multiply, byte-count multiply
//   and base add into the output register before it appears on out_ch; the sequencer
//   takes no new byte until that load. A lead byte or a zero byte leaves it idle.
//   A stalled output register holds the sequencer in its load step.
// Reset: rst_n is synchronous, active low; font_select, cursor, line and lead state clear.
module font_rom_glyph_address_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  frga_in_if.sink    in_ch,
  frga_out_if.source out_ch
);
  import frga_pkg::*;

  frga_cmd_t cmd;
  frga_sts_t sts;
  logic      in_ready;

  // Sequencer: takes one transaction in idle, then, for a byte that gives a cell, steps the multiply chain.
  frga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: cursor/lead bookkeeping at acceptance, then
  // index = row*94 + col, scale by glyph size, add font base.
  frga_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .text_byte     (in_ch.text_byte),
    .start_of_text (in_ch.start_of_text),
    .origin_x      (in_ch.origin_x),
    .origin_y      (in_ch.origin_y),
    .cmd           (cmd),
    .sts           (sts),
    .out_ch        (out_ch)
  );

endmodule
